>>> rtl/amri_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mass-to-rigid-inertia pipeline
// no dependencies

package amri_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   // quotient bits produced by the divider, one per stage
   localparam int DIV_BITS  = DATA_W + FRAC_BITS;
   // load stage, one stage per quotient bit, saturation stage
   localparam int DIV_LAT   = DIV_BITS + 2;
   // m*c*c needs 95 bits, the trace term at most 65, the sum of three terms fits in 98
   localparam int WIDE_W    = 98;
   localparam int SHIFT     = 2 * FRAC_BITS;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      word_type mass;
      word_type s_xx;
      word_type s_yy;
      word_type s_zz;
      word_type s_xy;
      word_type s_xz;
      word_type s_yz;
   } body_type;

   typedef struct packed {
      word_type mass;
      word_type com_x;
      word_type com_y;
      word_type com_z;
      word_type i_xx;
      word_type i_yy;
      word_type i_zz;
      word_type i_xy;
      word_type i_xz;
      word_type i_yz;
   } result_type;

endpackage

>>> rtl/amri_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for body transactions and result transactions
// depends on amri_pkg

interface amri_req_if;
   import amri_pkg::*;
   logic     valid;
   logic     ready;
   word_type mass;
   word_type first_moment_x;
   word_type first_moment_y;
   word_type first_moment_z;
   word_type second_moment_xx;
   word_type second_moment_yy;
   word_type second_moment_zz;
   word_type second_moment_xy;
   word_type second_moment_xz;
   word_type second_moment_yz;

   modport source (
      output valid, mass, first_moment_x, first_moment_y, first_moment_z,
             second_moment_xx, second_moment_yy, second_moment_zz,
             second_moment_xy, second_moment_xz, second_moment_yz,
      input  ready
   );
   modport sink (
      input  valid, mass, first_moment_x, first_moment_y, first_moment_z,
             second_moment_xx, second_moment_yy, second_moment_zz,
             second_moment_xy, second_moment_xz, second_moment_yz,
      output ready
   );
endinterface

interface amri_rsp_if;
   import amri_pkg::*;
   logic     valid;
   logic     ready;
   word_type out_mass;
   word_type com_x;
   word_type com_y;
   word_type com_z;
   word_type inertia_xx;
   word_type inertia_yy;
   word_type inertia_zz;
   word_type inertia_xy;
   word_type inertia_xz;
   word_type inertia_yz;

   modport source (
      output valid, out_mass, com_x, com_y, com_z, inertia_xx, inertia_yy,
             inertia_zz, inertia_xy, inertia_xz, inertia_yz,
      input  ready
   );
   modport sink (
      input  valid, out_mass, com_x, com_y, com_z, inertia_xx, inertia_yy,
             inertia_zz, inertia_xy, inertia_xz, inertia_yz,
      output ready
   );
endinterface

>>> rtl/amri_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, saturating signed result
// depends on amri_pkg

module amri_div import amri_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  word_type numer,
   input  word_type denom,
   output word_type quot
);

   logic [DIV_BITS-1:0] num_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0] q_ff   [DIV_BITS+1];
   logic [DATA_W-1:0]   rem_ff [DIV_BITS+1];
   logic [DATA_W-1:0]   den_ff [DIV_BITS+1];
   logic                neg_ff [DIV_BITS+1];
   logic [DATA_W-1:0]   abs_num;
   word_type            quot_ff;
   word_type            quot_in;

   assign abs_num = numer[DATA_W-1] ? DATA_W'(-numer) : DATA_W'(numer);

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= {abs_num, {FRAC_BITS{1'b0}}};
         q_ff[0]   <= '0;
         rem_ff[0] <= '0;
         den_ff[0] <= DATA_W'(denom);
         neg_ff[0] <= numer[DATA_W-1];
      end
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
      logic [DATA_W:0]   r2;
      logic [DATA_W:0]   diff;
      logic              ge;
      logic [DATA_W-1:0] rem_in;

      assign r2     = {rem_ff[k], num_ff[k][DIV_BITS-1]};
      assign diff   = r2 - {1'b0, den_ff[k]};
      assign ge     = (r2 >= {1'b0, den_ff[k]});
      assign rem_in = ge ? diff[DATA_W-1:0] : r2[DATA_W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k+1] <= num_ff[k] << 1;
            q_ff[k+1]   <= {q_ff[k][DIV_BITS-2:0], ge};
            rem_ff[k+1] <= rem_in;
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_comb begin
      logic [DIV_BITS-1:0] q;
      q = q_ff[DIV_BITS];
      if (!neg_ff[DIV_BITS]) begin
         if (|q[DIV_BITS-1:DATA_W-1]) quot_in = {1'b0, {(DATA_W-1){1'b1}}};
         else                         quot_in = word_type'(q[DATA_W-1:0]);
      end else begin
         if ((|q[DIV_BITS-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0])))
            quot_in = {1'b1, {(DATA_W-1){1'b0}}};
         else
            quot_in = word_type'(-q[DATA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

>>> rtl/amri_inr.sv
`timescale 1ns / 1ps
// five-stage inertia datapath: products of the centre, mass scaling, sums, floor and saturate
// depends on amri_pkg

module amri_inr import amri_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  body_type   body,
   input  word_type   com_x,
   input  word_type   com_y,
   input  word_type   com_z,
   output logic       out_valid,
   output result_type result
);

   localparam int XX = 0;
   localparam int YY = 1;
   localparam int ZZ = 2;
   localparam int XY = 3;
   localparam int XZ = 4;
   localparam int YZ = 5;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic mpos_in;
   logic mpos1_ff, mpos2_ff, mpos3_ff, mpos4_ff;
   word_type mass1_ff, mass2_ff, mass3_ff, mass4_ff;
   word_type c1_ff [3];
   word_type c2_ff [3];
   word_type c3_ff [3];
   word_type c4_ff [3];

   logic signed [2*DATA_W-1:0] p1_ff  [6];
   logic signed [DATA_W:0]     sd1_ff [3];
   word_type                   so1_ff [3];
   logic signed [2*DATA_W:0]   lo2_ff [6];
   logic signed [2*DATA_W-1:0] hi2_ff [6];
   logic signed [DATA_W:0]     sd2_ff [3];
   word_type                   so2_ff [3];
   logic signed [WIDE_W-1:0]   q3_ff  [6];
   logic signed [WIDE_W-1:0]   st3_ff [6];
   logic signed [WIDE_W-1:0]   e4_ff  [6];
   logic signed [WIDE_W-1:0]   e4_in  [6];
   word_type                   i5_in  [6];
   result_type                 res_ff;

   assign mpos_in = ~body.mass[DATA_W-1] & (|body.mass);

   // stage 1: centre products and trace sums
   always_ff @(posedge clock) begin
      if (en) begin
         mass1_ff   <= body.mass;
         mpos1_ff   <= mpos_in;
         c1_ff[0]   <= com_x;
         c1_ff[1]   <= com_y;
         c1_ff[2]   <= com_z;
         p1_ff[XX]  <= com_x * com_x;
         p1_ff[YY]  <= com_y * com_y;
         p1_ff[ZZ]  <= com_z * com_z;
         p1_ff[XY]  <= com_x * com_y;
         p1_ff[XZ]  <= com_x * com_z;
         p1_ff[YZ]  <= com_y * com_z;
         sd1_ff[0]  <= (DATA_W+1)'(body.s_yy) + (DATA_W+1)'(body.s_zz);
         sd1_ff[1]  <= (DATA_W+1)'(body.s_xx) + (DATA_W+1)'(body.s_zz);
         sd1_ff[2]  <= (DATA_W+1)'(body.s_xx) + (DATA_W+1)'(body.s_yy);
         so1_ff[0]  <= body.s_xy;
         so1_ff[1]  <= body.s_xz;
         so1_ff[2]  <= body.s_yz;
      end
   end

   // stage 2: mass times each product, split in halves
   always_ff @(posedge clock) begin
      if (en) begin
         mass2_ff <= mass1_ff;
         mpos2_ff <= mpos1_ff;
         c2_ff    <= c1_ff;
         sd2_ff   <= sd1_ff;
         so2_ff   <= so1_ff;
         for (int i = 0; i < 6; i++) begin
            lo2_ff[i] <= mass1_ff * $signed({1'b0, p1_ff[i][DATA_W-1:0]});
            hi2_ff[i] <= mass1_ff * $signed(p1_ff[i][2*DATA_W-1:DATA_W]);
         end
      end
   end

   // stage 3: recombine halves, scale tensor terms
   always_ff @(posedge clock) begin
      if (en) begin
         mass3_ff <= mass2_ff;
         mpos3_ff <= mpos2_ff;
         c3_ff    <= c2_ff;
         for (int i = 0; i < 6; i++) begin
            q3_ff[i] <= (WIDE_W'(hi2_ff[i]) <<< DATA_W) + WIDE_W'(lo2_ff[i]);
         end
         for (int i = 0; i < 3; i++) begin
            st3_ff[i]   <= WIDE_W'(sd2_ff[i]) <<< SHIFT;
            st3_ff[i+3] <= (-WIDE_W'(so2_ff[i])) <<< SHIFT;
         end
      end
   end

   // stage 4: inertia about the centre at full precision
   always_comb begin
      e4_in[XX] = st3_ff[XX] - q3_ff[YY] - q3_ff[ZZ];
      e4_in[YY] = st3_ff[YY] - q3_ff[XX] - q3_ff[ZZ];
      e4_in[ZZ] = st3_ff[ZZ] - q3_ff[XX] - q3_ff[YY];
      e4_in[XY] = st3_ff[XY] + q3_ff[XY];
      e4_in[XZ] = st3_ff[XZ] + q3_ff[XZ];
      e4_in[YZ] = st3_ff[YZ] + q3_ff[YZ];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mass4_ff <= mass3_ff;
         mpos4_ff <= mpos3_ff;
         c4_ff    <= c3_ff;
         e4_ff    <= e4_in;
      end
   end

   // stage 5: floor shift and saturate, or zero when the mass is not positive
   always_comb begin
      logic signed [WIDE_W-1:0] sh;
      for (int i = 0; i < 6; i++) begin
         sh = e4_ff[i] >>> SHIFT;
         if (!mpos4_ff)
            i5_in[i] = '0;
         else if ((&sh[WIDE_W-1:DATA_W-1]) || !(|sh[WIDE_W-1:DATA_W-1]))
            i5_in[i] = word_type'(sh[DATA_W-1:0]);
         else if (sh[WIDE_W-1])
            i5_in[i] = {1'b1, {(DATA_W-1){1'b0}}};
         else
            i5_in[i] = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.mass  <= mass4_ff;
         res_ff.com_x <= mpos4_ff ? c4_ff[0] : '0;
         res_ff.com_y <= mpos4_ff ? c4_ff[1] : '0;
         res_ff.com_z <= mpos4_ff ? c4_ff[2] : '0;
         res_ff.i_xx  <= i5_in[XX];
         res_ff.i_yy  <= i5_in[YY];
         res_ff.i_zz  <= i5_in[ZZ];
         res_ff.i_xy  <= i5_in[XY];
         res_ff.i_xz  <= i5_in[XZ];
         res_ff.i_yz  <= i5_in[YZ];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign result    = res_ff;

endmodule

>>> rtl/affine_mass_to_rigid_inertia.sv
`timescale 1ns / 1ps
// Takes one body transaction per cycle and returns mass, centre of mass and centre inertia.
// The centre comes from the bit-per-stage divider, and the inertia datapath follows it;
// the whole pipeline holds while a finished result waits at the output. Depends on amri_pkg,
// amri_if, amri_div and amri_inr.

module affine_mass_to_rigid_inertia import amri_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   amri_req_if.sink   req_chan,
   amri_rsp_if.source rsp_chan
);

   logic       en;
   logic       vld_ff  [DIV_LAT];
   body_type   side_ff [DIV_LAT];
   body_type   body_in;
   word_type   cx, cy, cz;
   logic       out_valid;
   result_type result;

   assign en             = ~out_valid | rsp_chan.ready;
   assign req_chan.ready = en;

   assign body_in = '{mass: req_chan.mass,
                      s_xx: req_chan.second_moment_xx, s_yy: req_chan.second_moment_yy,
                      s_zz: req_chan.second_moment_zz, s_xy: req_chan.second_moment_xy,
                      s_xz: req_chan.second_moment_xz, s_yz: req_chan.second_moment_yz};

   amri_div u_div_x (.clock, .en, .numer(req_chan.first_moment_x),
                     .denom(req_chan.mass), .quot(cx));
   amri_div u_div_y (.clock, .en, .numer(req_chan.first_moment_y),
                     .denom(req_chan.mass), .quot(cy));
   amri_div u_div_z (.clock, .en, .numer(req_chan.first_moment_z),
                     .denom(req_chan.mass), .quot(cz));

   // sideband travels alongside the divider stages
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= body_in;
         for (int k = 1; k < DIV_LAT; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_chan.valid;
         for (int k = 1; k < DIV_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   amri_inr u_inr (
      .clock, .reset, .en,
      .in_valid (vld_ff[DIV_LAT-1]),
      .body     (side_ff[DIV_LAT-1]),
      .com_x    (cx),
      .com_y    (cy),
      .com_z    (cz),
      .out_valid,
      .result
   );

   assign rsp_chan.valid      = out_valid;
   assign rsp_chan.out_mass   = result.mass;
   assign rsp_chan.com_x      = result.com_x;
   assign rsp_chan.com_y      = result.com_y;
   assign rsp_chan.com_z      = result.com_z;
   assign rsp_chan.inertia_xx = result.i_xx;
   assign rsp_chan.inertia_yy = result.i_yy;
   assign rsp_chan.inertia_zz = result.i_zz;
   assign rsp_chan.inertia_xy = result.i_xy;
   assign rsp_chan.inertia_xz = result.i_xz;
   assign rsp_chan.inertia_yz = result.i_yz;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench for affine_mass_to_rigid_inertia: random and directed body transactions
// checked against a scoreboard with its own center-of-mass and inertia predictor
// depends on amri_pkg, amri_if and the block itself

module testbench;
   import amri_pkg::*;

   typedef struct {
      word_type mass;
      word_type fm_x, fm_y, fm_z;
      word_type s_xx, s_yy, s_zz, s_xy, s_xz, s_yz;
   } body_item_type;

   localparam int RANDOM_ITEMS = 1530;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;

   class inertia_scoreboard;
      result_type expected_q[$];
      int errors = 0;

      function logic signed [127:0] mul_wide(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [127:0] wa, wb;
         wa = 128'(a);
         wb = 128'(b);
         return wa * wb;
      endfunction

      function word_type sat32(logic signed [127:0] v);
         logic signed [127:0] hi_lim, lo_lim;
         hi_lim = 128'sd2147483647;
         lo_lim = -hi_lim - 128'sd1;
         if (v > hi_lim) return word_type'(hi_lim);
         if (v < lo_lim) return word_type'(lo_lim);
         return word_type'(v);
      endfunction

      function word_type inertia_entry(logic signed [63:0] s_term, logic signed [127:0] mterm);
         logic signed [127:0] acc;
         acc = mul_wide(s_term, 64'sd1 <<< SHIFT) + mterm;
         return sat32(acc >>> SHIFT);
      endfunction

      function void note_body(body_item_type b);
         result_type r;
         logic signed [63:0] m, num, c [3], mc [3], fm [3];
         m = 64'(b.mass);
         fm[0] = 64'(b.fm_x);
         fm[1] = 64'(b.fm_y);
         fm[2] = 64'(b.fm_z);
         r = '0;
         r.mass = b.mass;
         if (m > 0) begin
            for (int i = 0; i < 3; i++) begin
               num = fm[i] <<< FRAC_BITS;
               c[i] = 64'(sat32(128'(num / m)));
               mc[i] = m * c[i];
            end
            r.com_x = word_type'(c[0]);
            r.com_y = word_type'(c[1]);
            r.com_z = word_type'(c[2]);
            r.i_xx = inertia_entry(64'(b.s_yy) + 64'(b.s_zz),
                                   -(mul_wide(mc[1], c[1]) + mul_wide(mc[2], c[2])));
            r.i_yy = inertia_entry(64'(b.s_xx) + 64'(b.s_zz),
                                   -(mul_wide(mc[0], c[0]) + mul_wide(mc[2], c[2])));
            r.i_zz = inertia_entry(64'(b.s_xx) + 64'(b.s_yy),
                                   -(mul_wide(mc[0], c[0]) + mul_wide(mc[1], c[1])));
            r.i_xy = inertia_entry(-64'(b.s_xy), mul_wide(mc[0], c[1]));
            r.i_xz = inertia_entry(-64'(b.s_xz), mul_wide(mc[0], c[2]));
            r.i_yz = inertia_entry(-64'(b.s_yz), mul_wide(mc[1], c[2]));
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(result_type act);
         result_type exp;
         logic [10*DATA_W-1:0] ev, av;
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, act);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         ev = exp;
         av = act;
         for (int f = 9; f >= 0; f--) begin
            if (ev[f*DATA_W +: DATA_W] !== av[f*DATA_W +: DATA_W]) begin
               $display("%0t field %0d mismatch: expected %h, actual %h", $time, 9 - f,
                        ev[f*DATA_W +: DATA_W], av[f*DATA_W +: DATA_W]);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles = 0;
   int   received = 0;
   int   gap_max = 17;
   int   stall_max = 17;
   inertia_scoreboard board;

   amri_req_if req_bus();
   amri_rsp_if rsp_bus();

   affine_mass_to_rigid_inertia dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   function automatic word_type rand_span(int bits);
      int v;
      v = $urandom_range((1 << bits) - 1, 0);
      return ($urandom_range(1, 0)) ? word_type'(-v) : word_type'(v);
   endfunction

   function automatic body_item_type make_body(word_type m, word_type f, word_type s);
      body_item_type b;
      b.mass = m;
      b.fm_x = f; b.fm_y = f; b.fm_z = f;
      b.s_xx = s; b.s_yy = s; b.s_zz = s; b.s_xy = s; b.s_xz = s; b.s_yz = s;
      return b;
   endfunction

   function automatic body_item_type random_body();
      body_item_type b;
      logic signed [63:0] m64, cx, cy, cz;
      if ($urandom_range(9, 0) < 3) begin
         b.mass = rand_word();
         b.fm_x = rand_word(); b.fm_y = rand_word(); b.fm_z = rand_word();
         b.s_xx = rand_word(); b.s_yy = rand_word(); b.s_zz = rand_word();
         b.s_xy = rand_word(); b.s_xz = rand_word(); b.s_yz = rand_word();
      end else begin
         m64 = 64'($urandom_range(1 << $urandom_range(24, 1), 1));
         cx = 64'(rand_span(22));
         cy = 64'(rand_span(22));
         cz = 64'(rand_span(22));
         b.mass = word_type'(m64);
         b.fm_x = word_type'((m64 * cx) >>> FRAC_BITS);
         b.fm_y = word_type'((m64 * cy) >>> FRAC_BITS);
         b.fm_z = word_type'((m64 * cz) >>> FRAC_BITS);
         b.s_xx = rand_span(28); b.s_yy = rand_span(28); b.s_zz = rand_span(28);
         b.s_xy = rand_span(27); b.s_xz = rand_span(27); b.s_yz = rand_span(27);
      end
      return b;
   endfunction

   task automatic send_body(body_item_type b);
      int gap;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.mass             <= b.mass;
      req_bus.first_moment_x   <= b.fm_x;
      req_bus.first_moment_y   <= b.fm_y;
      req_bus.first_moment_z   <= b.fm_z;
      req_bus.second_moment_xx <= b.s_xx;
      req_bus.second_moment_yy <= b.s_yy;
      req_bus.second_moment_zz <= b.s_zz;
      req_bus.second_moment_xy <= b.s_xy;
      req_bus.second_moment_xz <= b.s_xz;
      req_bus.second_moment_yz <= b.s_yz;
      do @(posedge clock); while (!req_bus.ready);
      board.note_body(b);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   // receiver with random stalls and one long hold-off
   initial begin
      result_type r;
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (received == 200) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            stall = $urandom_range(stall_max, 0);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         r.mass  = rsp_bus.out_mass;
         r.com_x = rsp_bus.com_x;
         r.com_y = rsp_bus.com_y;
         r.com_z = rsp_bus.com_z;
         r.i_xx  = rsp_bus.inertia_xx;
         r.i_yy  = rsp_bus.inertia_yy;
         r.i_zz  = rsp_bus.inertia_zz;
         r.i_xy  = rsp_bus.inertia_xy;
         r.i_xz  = rsp_bus.inertia_xz;
         r.i_yz  = rsp_bus.inertia_yz;
         board.check_result(r);
         received++;
      end
   end

   initial begin
      word_type wmax, wmin;
      body_item_type b;
      board = new();
      wmax = 32'sh7fffffff;
      wmin = 32'sh80000000;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mass <= '0;
      req_bus.first_moment_x <= '0;
      req_bus.first_moment_y <= '0;
      req_bus.first_moment_z <= '0;
      req_bus.second_moment_xx <= '0;
      req_bus.second_moment_yy <= '0;
      req_bus.second_moment_zz <= '0;
      req_bus.second_moment_xy <= '0;
      req_bus.second_moment_xz <= '0;
      req_bus.second_moment_yz <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and negative mass, extremes of every field
      send_body(make_body('0, wmax, wmax));
      send_body(make_body(-32'sd65536, 32'sd65536, 32'sd65536));
      send_body(make_body(wmin, wmax, wmin));
      send_body(make_body(32'sd1, wmax, wmax));
      send_body(make_body(32'sd1, wmin, wmin));
      send_body(make_body(wmax, wmax, wmax));
      send_body(make_body(wmax, wmin, wmin));
      send_body(make_body(wmax, 32'sd1, '0));
      send_body(make_body(32'sd65536, 32'sd65536, 32'sd65536));
      send_body(make_body(32'sd65536, -32'sd65536, -32'sd131072));
      send_body(make_body(32'sd3, -32'sd7, 32'sd5));
      send_body(make_body(32'sd2, wmax, wmin));
      send_body(make_body(32'sd131072, '0, wmax));
      send_body(make_body(32'sd131072, '0, wmin));
      b = make_body(32'sd65536, 32'sd32768, '0);
      b.fm_y = -32'sd98304;
      b.fm_z = 32'sd1;
      b.s_xx = wmax; b.s_yy = wmax; b.s_zz = wmin;
      b.s_xy = wmin; b.s_xz = wmax; b.s_yz = 32'sd12345;
      send_body(b);
      b.mass = 32'sd7;
      b.fm_x = 32'sd1 <<< 20;
      send_body(b);
      wait_idle();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ((n / 150) % 4 == 3) begin
            gap_max = 0;
            stall_max = 0;
         end else begin
            gap_max = 17;
            stall_max = 17;
         end
         if (n == 800) wait_idle();
         send_body(random_body());
      end
      req_bus.valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/amri_pkg.sv
rtl/amri_if.sv
rtl/amri_div.sv
rtl/amri_inr.sv
rtl/affine_mass_to_rigid_inertia.sv
test/testbench.sv
